>>> hw/rtl/kds_pkg.sv
package kds_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_POINTS = 32;
  localparam int DEF_DIST_WIDTH = 32;

  // Fixed field widths of the register file and result channel
  localparam int PCFG_W     = 6;
  localparam int RANK_W     = 5;
  localparam int IDX_OUT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATE = 2'd2;

  // Register reset values
  localparam logic [PCFG_W-1:0] RST_POINTS = 6'd32;
  localparam logic [RANK_W-1:0] RST_RANK   = 5'd1;

  typedef struct packed {
    logic [PCFG_W-1:0] points;
    logic [RANK_W-1:0] rank;
    logic              negate;
  } kds_cfg_t;

  // Controller state
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } kds_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_wr;
    logic pt_rst;
    logic pt_next;
    logic clr;
    logic scan;
    logic out_load;
  } kds_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_done;
    logic scan_end;
    logic last_pt;
    logic out_free;
  } kds_sts_t;

endpackage

>>> hw/rtl/knn_distance_select_core.sv
// k-th nearest neighbour distance selector.
// Input channel (in_valid/in_ready/in_distance): one unsigned Q16.16 pair
// distance per transaction, upper triangle in order j = 1.., i = 0..j-1.
// During load one transaction is taken every cycle.
// The transaction that completes the triangle starts the selection pass:
// for each of the P points the store is scanned once (P reads, one per
// cycle through the single read port), the last read is folded into the
// sorted list, and the result is registered. One result is produced per
// point. Results carry point_index, kth_distance (negated when
// configured) and last_point on the final point. A stall on out_ready
// holds the result register and pauses the pass; after the last result
// is registered, loading resumes at once. The user writes configuration
// (cfg_wr_en/cfg_index/cfg_wr_data) only while idle; the core does not
// enforce this. Synchronous reset clears the load count and returns
// registers to 32 points, rank 1, no negation; the distance store is
// not cleared.
module knn_distance_select_core
  import kds_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int DIST_WIDTH = DEF_DIST_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [DIST_WIDTH-1:0]       in_distance,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [IDX_OUT_W-1:0]        out_point_index,
  output logic signed [DIST_WIDTH:0]  out_kth_distance,
  output logic                        out_last_point,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wr_data
);

  // Configuration registers
  kds_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POINTS: cfg_nxt.points = cfg_wr_data[PCFG_W-1:0];
        REG_RANK:   cfg_nxt.rank   = cfg_wr_data[RANK_W-1:0];
        REG_NEGATE: cfg_nxt.negate = cfg_wr_data[0];
        default:    cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.points <= RST_POINTS;
      cfg_r.rank   <= RST_RANK;
      cfg_r.negate <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  kds_cmd_t cmd;
  kds_sts_t sts;

  kds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kds_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_distance      (in_distance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_index  (out_point_index),
    .out_kth_distance (out_kth_distance),
    .out_last_point   (out_last_point)
  );

endmodule

>>> hw/rtl/kds_ram.sv
module kds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 496,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/kds_ctrl.sv
module kds_ctrl
  import kds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kds_sts_t sts,
  output kds_cmd_t cmd
);

  kds_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (sts.load_done) begin
            cmd.pt_rst = 1'b1;
            cmd.clr    = 1'b1;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last read of the point lands in the list
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.last_pt) begin
            state_nxt = ST_LOAD;
          end else begin
            cmd.pt_next = 1'b1;
            cmd.clr     = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
    endcase
  end

endmodule

>>> hw/rtl/kds_dpath.sv
module kds_dpath
  import kds_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int DIST_WIDTH = DEF_DIST_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kds_cfg_t                     cfg,
  input  kds_cmd_t                     cmd,
  output kds_sts_t                     sts,
  input  logic [DIST_WIDTH-1:0]        in_distance,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [IDX_OUT_W-1:0]         out_point_index,
  output logic signed [DIST_WIDTH:0]   out_kth_distance,
  output logic                         out_last_point
);

  localparam int STORE_DEPTH = (MAX_POINTS * (MAX_POINTS - 1)) / 2;
  localparam int LIST_DEPTH  = MAX_POINTS - 1;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int PT_W        = $clog2(MAX_POINTS);
  localparam int PW          = $clog2(MAX_POINTS + 1);
  localparam int LIDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW          = (PCFG_W > PW) ? PCFG_W : PW;
  localparam int KW          = (RANK_W > PW) ? RANK_W : PW;

  // Effective point count, triangle size and rank
  logic [CW-1:0]     pts_ext;
  logic [PW-1:0]     p_eff;
  logic [PW-1:0]     pm1;
  logic [PT_W-1:0]   last_idx;
  logic [2*PW-1:0]   tri_prod;
  logic [CNT_W-1:0]  tri_total;
  logic [KW-1:0]     rank_ext;
  logic [KW-1:0]     pm1_k;
  logic [KW-1:0]     k_one;
  logic [KW-1:0]     k_eff;
  logic [LIDX_W-1:0] kidx;

  always_comb begin
    pts_ext = CW'(cfg.points);
    priority if (pts_ext < CW'(2)) begin
      p_eff = PW'(2);
    end else if (pts_ext > CW'(MAX_POINTS)) begin
      p_eff = PW'(MAX_POINTS);
    end else begin
      p_eff = PW'(pts_ext);
    end
    pm1       = p_eff - PW'(1);
    last_idx  = PT_W'(pm1);
    tri_prod  = (2*PW)'(p_eff) * (2*PW)'(pm1);
    tri_total = CNT_W'(tri_prod >> 1);
    rank_ext  = KW'(cfg.rank);
    pm1_k     = KW'(pm1);
    k_one     = (rank_ext == '0) ? KW'(1) : rank_ext;
    k_eff     = (k_one > pm1_k) ? pm1_k : k_one;
    kidx      = LIDX_W'(k_eff - KW'(1));
  end

  // Load counter
  logic [CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = load_cnt_r + CNT_W'(1);

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (cmd.load_wr) begin
      load_cnt_nxt = sts.load_done ? '0 : cnt_inc;
    end
  end

  // Scan position: point i, partner j and their triangle row bases
  logic [PT_W-1:0]   pt_r, pt_nxt;
  logic [PT_W-1:0]   j_r, j_nxt;
  logic [ADDR_W-1:0] base_i_r, base_i_nxt;
  logic [ADDR_W-1:0] base_j_r, base_j_nxt;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_vld_r, rd_vld_nxt;

  always_comb begin
    pt_nxt     = pt_r;
    base_i_nxt = base_i_r;
    j_nxt      = j_r;
    base_j_nxt = base_j_r;
    if (cmd.pt_rst) begin
      pt_nxt     = '0;
      base_i_nxt = '0;
    end else if (cmd.pt_next) begin
      pt_nxt     = pt_r + PT_W'(1);
      base_i_nxt = base_i_r + ADDR_W'(pt_r);
    end
    if (cmd.clr) begin
      j_nxt      = '0;
      base_j_nxt = '0;
    end else if (cmd.scan) begin
      j_nxt      = j_r + PT_W'(1);
      base_j_nxt = base_j_r + ADDR_W'(j_r);
    end
    rd_vld_nxt = cmd.scan && (j_r != pt_r);
  end

  // Entry of pair (i, j): row of the larger index plus the smaller one
  assign rd_addr = (j_r < pt_r) ? base_i_r + ADDR_W'(j_r)
                                : base_j_r + ADDR_W'(pt_r);

  // Distance store
  logic [DIST_WIDTH-1:0] rd_data;

  kds_ram #(
    .WIDTH (DIST_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.load_wr),
    .wr_addr (ADDR_W'(load_cnt_r)),
    .wr_data (in_distance),
    .rd_en   (cmd.scan),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sorted list of smallest distances, one insertion per cycle
  logic [DIST_WIDTH-1:0] list_r   [LIST_DEPTH];
  logic [DIST_WIDTH-1:0] list_nxt [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] lt;

  always_comb begin
    for (int m = 0; m < LIST_DEPTH; m++) begin
      lt[m]       = rd_data < list_r[m];
      list_nxt[m] = list_r[m];
    end
    if (cmd.clr) begin
      for (int m = 0; m < LIST_DEPTH; m++) begin
        list_nxt[m] = '1;
      end
    end else if (rd_vld_r) begin
      if (lt[0]) begin
        list_nxt[0] = rd_data;
      end
      for (int m = 1; m < LIST_DEPTH; m++) begin
        if (lt[m]) begin
          list_nxt[m] = lt[m-1] ? list_r[m-1] : rd_data;
        end
      end
    end
  end

  // Result register
  logic                       out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0]       out_idx_r;
  logic signed [DIST_WIDTH:0] out_kth_r;
  logic                       out_last_r;
  logic [DIST_WIDTH:0]        kth_ext;

  assign kth_ext = {1'b0, list_r[kidx]};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      load_cnt_r  <= load_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and payload
  always_ff @(posedge clk) begin
    pt_r     <= pt_nxt;
    j_r      <= j_nxt;
    base_i_r <= base_i_nxt;
    base_j_r <= base_j_nxt;
    for (int m = 0; m < LIST_DEPTH; m++) begin
      list_r[m] <= list_nxt[m];
    end
    if (cmd.out_load) begin
      out_idx_r  <= IDX_OUT_W'(pt_r);
      out_kth_r  <= cfg.negate ? -$signed(kth_ext) : $signed(kth_ext);
      out_last_r <= (pt_r == last_idx);
    end
  end

  // Status
  always_comb begin
    sts.load_done = cnt_inc >= tri_total;
    sts.scan_end  = (j_r == last_idx);
    sts.last_pt   = (pt_r == last_idx);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_point_index  = out_idx_r;
  assign out_kth_distance = out_kth_r;
  assign out_last_point   = out_last_r;

  // Checks
  a_rd_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && (j_r != pt_r)) |-> ((ADDR_W+1)'(rd_addr) < (ADDR_W+1)'(STORE_DEPTH)))
    else $error("store read beyond triangle");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(load_cnt_r) < (CNT_W+1)'(STORE_DEPTH))
    else $error("load count beyond store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_no_read_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !rd_vld_r)
    else $error("result taken with a read in flight");

endmodule
